### src/ptsf_pkg.sv
package ptsf_pkg;

   // Palette geometry.
   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_IDX_W       = $clog2(PALETTE_ENTRIES);

   // Fixed field widths.
   localparam int PIX_W      = 32;
   localparam int CHAN_W     = 8;
   localparam int IDX_W      = 8;
   localparam int SHIFT_W    = 5;
   localparam int SHIFTS_W   = 4 * SHIFT_W;
   localparam int COUNT_W    = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // One more bit than a pixel index, so that the palette size itself fits.
   localparam logic [IDX_W:0] PAL_LIMIT = (IDX_W + 1)'(PALETTE_ENTRIES);

   // Word actions.
   localparam logic ACTION_CONVERT   = 1'b0;
   localparam logic ACTION_PAL_WRITE = 1'b1;

   // Source modes.
   localparam logic [1:0] MODE_RGBA    = 2'd0;
   localparam logic [1:0] MODE_GRAY    = 2'd1;
   localparam logic [1:0] MODE_INDEXED = 2'd2;
   localparam logic [1:0] MODE_BITMAP  = 2'd3;

   // Output depths.
   localparam logic [1:0] DEPTH_8  = 2'd0;
   localparam logic [1:0] DEPTH_16 = 2'd1;
   localparam logic [1:0] DEPTH_24 = 2'd2;
   localparam logic [1:0] DEPTH_32 = 2'd3;

   // Byte counts per depth.
   localparam logic [COUNT_W-1:0] BYTES_8  = 3'd1;
   localparam logic [COUNT_W-1:0] BYTES_16 = 3'd2;
   localparam logic [COUNT_W-1:0] BYTES_24 = 3'd3;
   localparam logic [COUNT_W-1:0] BYTES_32 = 3'd4;

   // Register indexes.
   localparam logic [CSR_ADDR_W-1:0] REG_SOURCE_MODE    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_OUTPUT_DEPTH   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_CHANNEL_SHIFTS = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_RED_MASK       = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_GREEN_MASK     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_BLUE_MASK      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_ALPHA_MASK     = 3'd6;

   typedef struct packed {
      logic [1:0]          source_mode;
      logic [1:0]          output_depth;
      logic [SHIFTS_W-1:0] channel_shifts;
      logic [PIX_W-1:0]    red_mask;
      logic [PIX_W-1:0]    green_mask;
      logic [PIX_W-1:0]    blue_mask;
      logic [PIX_W-1:0]    alpha_mask;
   } cfg_type;

   // Pixel held in the palette read stage.
   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic             in_range;
   } stage_type;

   function automatic logic [PIX_W-1:0] place_channel(input logic [CHAN_W-1:0]  chan,
                                                      input logic [SHIFT_W-1:0] sh,
                                                      input logic [PIX_W-1:0]   mask);
      return (PIX_W'(chan) << sh) & mask;
   endfunction

endpackage

### src/ptsf_if.sv
interface ptsf_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [ptsf_pkg::PIX_W-1:0]   pixel_value;
   logic [ptsf_pkg::IDX_W-1:0]   palette_index;
   logic [ptsf_pkg::PIX_W-1:0]   palette_color;

   modport source (output valid, action, pixel_value, palette_index, palette_color,
                   input ready);
   modport sink (input valid, action, pixel_value, palette_index, palette_color,
                 output ready);
endinterface

interface ptsf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ptsf_pkg::PIX_W-1:0]   surface_word;
   logic [ptsf_pkg::COUNT_W-1:0] byte_count;

   modport source (output valid, surface_word, byte_count, input ready);
   modport sink (input valid, surface_word, byte_count, output ready);
endinterface

### src/pixel_to_surface_format_packer_top.sv
// Pixel to surface format packer.
//
// Words arrive on req_ch with valid/ready. A convert word (action 0) yields
// exactly one word on rsp_ch: the pixel packed by the per-channel shifts and
// masks and cut to the output depth, with its byte count. A palette-write
// word (action 1) stores palette_color into the palette and yields nothing.
// The user must write the seven registers via csr_we/csr_index/csr_wdata
// only while no word is in flight; the block itself does not enforce this.
//
// An accepted word goes through the read stage, where the synchronous RAM
// reads the palette, and then through the packing logic into the output
// register. Throughput is one word per clock while the receiver does not
// stall; the RAM read port and write port are used at most once each per
// accepted word, so nothing stalls back to back. A palette entry written
// by one word is visible to a convert word accepted in the very next cycle.
//
// Reset (synchronous) empties the pipeline and restores the register
// defaults; the palette is not cleared. When the receiver stalls, the output
// register holds its word, the read stage fills behind it, and req_ch.ready
// drops only once both are full.
module pixel_to_surface_format_packer_top (
   input  logic                            clock,
   input  logic                            reset,
   ptsf_req_if.sink                        req_ch,
   ptsf_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [ptsf_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [ptsf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ptsf_pkg::*;

   cfg_type          cfg;
   logic             accept;
   logic             convert;
   logic             pal_wr_en;
   logic [PIX_W-1:0] pal_data;
   logic             s1_ready;
   logic             s1_valid_ff, s1_valid_in;
   stage_type        s1_data_ff;

   ptsf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The read stage takes a new word whenever it is empty or moving on.
   assign req_ch.ready = !s1_valid_ff || s1_ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign convert      = accept && (req_ch.action == ACTION_CONVERT);

   // Writes beyond the palette are dropped.
   assign pal_wr_en = accept && (req_ch.action == ACTION_PAL_WRITE) &&
                      ({1'b0, req_ch.palette_index} < PAL_LIMIT);

   // The palette is read for every convert word; the packer decides whether
   // the colour is used. Since the RAM is written at the accepting edge and
   // read at a later one, a write followed at once by a read of the same
   // entry needs no forwarding.
   ptsf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (req_ch.palette_index[PAL_IDX_W-1:0]),
      .wr_data (req_ch.palette_color),
      .rd_en   (convert),
      .rd_addr (req_ch.pixel_value[PAL_IDX_W-1:0]),
      .rd_data (pal_data)
   );

   assign s1_valid_in = req_ch.ready ? convert : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (convert) begin
         s1_data_ff.pix      <= req_ch.pixel_value;
         s1_data_ff.in_range <= ({1'b0, req_ch.pixel_value[IDX_W-1:0]} < PAL_LIMIT);
      end
   end

   ptsf_pack u_pack (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .s1_valid (s1_valid_ff),
      .s1_data  (s1_data_ff),
      .pal_data (pal_data),
      .s1_ready (s1_ready),
      .rsp      (rsp_ch)
   );

   a_convert_enters: assert property (@(posedge clock) disable iff (reset)
      convert |=> s1_valid_ff)
      else $error("accepted pixel did not reach the read stage");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_ready |=> s1_valid_ff && $stable(s1_data_ff))
      else $error("stalled read stage lost its pixel");

endmodule

### src/ptsf_ram.sv
module ptsf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/ptsf_csr.sv
module ptsf_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ptsf_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [ptsf_pkg::CSR_DATA_W-1:0] csr_wdata,
   output ptsf_pkg::cfg_type               cfg
);
   import ptsf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SOURCE_MODE:    cfg_in.source_mode    = csr_wdata[1:0];
            REG_OUTPUT_DEPTH:   cfg_in.output_depth   = csr_wdata[1:0];
            REG_CHANNEL_SHIFTS: cfg_in.channel_shifts = csr_wdata[SHIFTS_W-1:0];
            REG_RED_MASK:       cfg_in.red_mask       = csr_wdata;
            REG_GREEN_MASK:     cfg_in.green_mask     = csr_wdata;
            REG_BLUE_MASK:      cfg_in.blue_mask      = csr_wdata;
            REG_ALPHA_MASK:     cfg_in.alpha_mask     = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_mode    <= MODE_RGBA;
         cfg_ff.output_depth   <= DEPTH_32;
         cfg_ff.channel_shifts <= '0;
         cfg_ff.red_mask       <= 32'h0000_00FF;
         cfg_ff.green_mask     <= 32'h0000_FF00;
         cfg_ff.blue_mask      <= 32'h00FF_0000;
         cfg_ff.alpha_mask     <= 32'hFF00_0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/ptsf_pack.sv
module ptsf_pack (
   input  logic                         clock,
   input  logic                         reset,
   input  ptsf_pkg::cfg_type            cfg,
   input  logic                         s1_valid,
   input  ptsf_pkg::stage_type          s1_data,
   input  logic [ptsf_pkg::PIX_W-1:0]   pal_data,
   output logic                         s1_ready,
   ptsf_rsp_if.source                   rsp
);
   import ptsf_pkg::*;

   logic [PIX_W-1:0]   color;
   logic [CHAN_W-1:0]  red, green, blue, alpha;
   logic [PIX_W-1:0]   packed_word;
   logic [PIX_W-1:0]   word_in;
   logic [COUNT_W-1:0] count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]   rsp_word_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   // Channel extraction: gray fans one byte out to red, green and blue.
   always_comb begin
      if (cfg.source_mode inside {MODE_INDEXED, MODE_BITMAP}) begin
         color = s1_data.in_range ? pal_data : '0;
      end else begin
         color = s1_data.pix;
      end
      if (cfg.source_mode == MODE_GRAY) begin
         red   = s1_data.pix[7:0];
         green = s1_data.pix[7:0];
         blue  = s1_data.pix[7:0];
         alpha = s1_data.pix[15:8];
      end else begin
         red   = color[7:0];
         green = color[15:8];
         blue  = color[23:16];
         alpha = color[31:24];
      end
   end

   assign packed_word =
      place_channel(red,   cfg.channel_shifts[4:0],   cfg.red_mask)   |
      place_channel(green, cfg.channel_shifts[9:5],   cfg.green_mask) |
      place_channel(blue,  cfg.channel_shifts[14:10], cfg.blue_mask)  |
      place_channel(alpha, cfg.channel_shifts[19:15], cfg.alpha_mask);

   always_comb begin
      case (cfg.output_depth)
         DEPTH_8: begin
            word_in  = {24'd0, packed_word[7:0]};
            count_in = BYTES_8;
         end
         DEPTH_16: begin
            word_in  = {16'd0, packed_word[15:0]};
            count_in = BYTES_16;
         end
         DEPTH_24: begin
            word_in  = {8'd0, packed_word[23:0]};
            count_in = BYTES_24;
         end
         default: begin
            word_in  = packed_word;
            count_in = BYTES_32;
         end
      endcase
   end

   // The output register frees up whenever the receiver takes its word.
   assign s1_ready     = !rsp_valid_ff || rsp.ready;
   assign rsp_valid_in = s1_ready ? s1_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_ready && s1_valid) begin
         rsp_word_ff  <= word_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.surface_word = rsp_word_ff;
   assign rsp.byte_count   = rsp_count_ff;

   a_count_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff == BYTES_8 || rsp_count_ff == BYTES_16 ||
                        rsp_count_ff == BYTES_24 || rsp_count_ff == BYTES_32))
      else $error("byte count out of range");

   a_word_truncated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_count_ff == BYTES_8 |-> rsp_word_ff[31:8] == 24'd0)
      else $error("8-bit word has bits above its depth");

endmodule

### verif/ptsf_surface_checker.sv
`timescale 1ns / 1ps

module ptsf_surface_checker (
   input  logic                            clock,
   input  logic                            reset,
   ptsf_req_if                             req_mon,
   ptsf_rsp_if                             rsp_mon,
   input  logic                            csr_we,
   input  logic [ptsf_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [ptsf_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatches,
   output int                              words_outstanding,
   output int                              words_compared
);
   import ptsf_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0]   surface_word;
      logic [COUNT_W-1:0] byte_count;
   } surface_result_type;

   // Shadow copy of the register file and of the palette.
   logic [1:0]          shadow_mode;
   logic [1:0]          shadow_depth;
   logic [SHIFTS_W-1:0] shadow_shifts;
   logic [PIX_W-1:0]    shadow_mask [4];
   logic [PIX_W-1:0]    shadow_palette [PALETTE_ENTRIES];

   surface_result_type packed_words_due [$];

   // Packs one pixel under the current shadow settings.
   function automatic surface_result_type pack_surface_word(input logic [PIX_W-1:0] pix);
      logic [CHAN_W-1:0]  chan [4];
      logic [PIX_W-1:0]   color;
      logic [PIX_W-1:0]   word;
      surface_result_type res;
      if (shadow_mode == MODE_GRAY) begin
         chan[0] = pix[7:0];
         chan[1] = pix[7:0];
         chan[2] = pix[7:0];
         chan[3] = pix[15:8];
      end else begin
         color = pix;
         if (shadow_mode == MODE_INDEXED || shadow_mode == MODE_BITMAP) begin
            if (int'(pix[IDX_W-1:0]) < PALETTE_ENTRIES)
               color = shadow_palette[pix[IDX_W-1:0]];
            else
               color = '0;
         end
         for (int k = 0; k < 4; k++)
            chan[k] = color[CHAN_W*k +: CHAN_W];
      end
      word = '0;
      for (int k = 0; k < 4; k++)
         word |= ({24'd0, chan[k]} << shadow_shifts[SHIFT_W*k +: SHIFT_W]) & shadow_mask[k];
      case (shadow_depth)
         DEPTH_8: begin
            res.surface_word = {24'd0, word[7:0]};
            res.byte_count   = BYTES_8;
         end
         DEPTH_16: begin
            res.surface_word = {16'd0, word[15:0]};
            res.byte_count   = BYTES_16;
         end
         DEPTH_24: begin
            res.surface_word = {8'd0, word[23:0]};
            res.byte_count   = BYTES_24;
         end
         default: begin
            res.surface_word = word;
            res.byte_count   = BYTES_32;
         end
      endcase
      return res;
   endfunction

   initial begin
      mismatches        = 0;
      words_outstanding = 0;
      words_compared    = 0;
   end

   always @(posedge clock) begin
      surface_result_type due;
      int                 errs;
      errs = 0;
      if (reset) begin
         shadow_mode    = MODE_RGBA;
         shadow_depth   = DEPTH_32;
         shadow_shifts  = '0;
         shadow_mask[0] = 32'h0000_00FF;
         shadow_mask[1] = 32'h0000_FF00;
         shadow_mask[2] = 32'h00FF_0000;
         shadow_mask[3] = 32'hFF00_0000;
         packed_words_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_SOURCE_MODE:    shadow_mode   = csr_wdata[1:0];
               REG_OUTPUT_DEPTH:   shadow_depth  = csr_wdata[1:0];
               REG_CHANNEL_SHIFTS: shadow_shifts = csr_wdata[SHIFTS_W-1:0];
               REG_RED_MASK:       shadow_mask[0] = csr_wdata;
               REG_GREEN_MASK:     shadow_mask[1] = csr_wdata;
               REG_BLUE_MASK:      shadow_mask[2] = csr_wdata;
               REG_ALPHA_MASK:     shadow_mask[3] = csr_wdata;
               default: ;
            endcase
         end

         // A result leaves only after the read stage and the output register, so the
         // older entries are retired before the word accepted at this edge is queued.
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (packed_words_due.size() == 0) begin
               $display("%0t: surface word %h arrived with no pixel outstanding",
                        $time, rsp_mon.surface_word);
               errs++;
            end else begin
               due = packed_words_due.pop_front();
               words_compared <= words_compared + 1;
               if (rsp_mon.surface_word !== due.surface_word) begin
                  $display("%0t: surface_word expected %h, actual %h",
                           $time, due.surface_word, rsp_mon.surface_word);
                  errs++;
               end
               if (rsp_mon.byte_count !== due.byte_count) begin
                  $display("%0t: byte_count expected %0d, actual %0d",
                           $time, due.byte_count, rsp_mon.byte_count);
                  errs++;
               end
            end
         end

         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            if (req_mon.action == ACTION_PAL_WRITE) begin
               if (int'(req_mon.palette_index) < PALETTE_ENTRIES)
                  shadow_palette[req_mon.palette_index] = req_mon.palette_color;
            end else begin
               packed_words_due.push_back(pack_surface_word(req_mon.pixel_value));
            end
         end
      end
      if (errs != 0)
         mismatches <= mismatches + errs;
      words_outstanding <= packed_words_due.size();
   end

endmodule

### verif/pixel_to_surface_format_packer_top_tb.sv
`timescale 1ns / 1ps

module pixel_to_surface_format_packer_top_tb;
   import ptsf_pkg::*;

   // The run is bounded by this many clock cycles; a correct run needs a
   // small fraction of it even with every stall and gap at its longest.
   localparam int unsigned CYCLE_LIMIT    = 200000;
   // Length of the long receiver hold-off that fills the pipeline.
   localparam int          HOLDOFF_CYCLES = 300;
   localparam int          RANDOM_PHASES  = 8;
   localparam int          PHASE_WORDS    = 55;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ptsf_req_if req_ch ();
   ptsf_rsp_if rsp_ch ();

   int mismatches;
   int words_outstanding;
   int words_compared;

   // Stimulus bookkeeping. The palette comes up undefined, so converts in the
   // indexed and bitmap modes only ever point at entries loaded earlier.
   cfg_type          active_cfg;
   bit               palette_loaded [PALETTE_ENTRIES];
   logic [IDX_W-1:0] loaded_entries [$];
   int               burst_left;
   int               burst_max;
   int               gap_max;
   int               pixels_sent;
   int               palette_loads;
   int               settings_applied;
   int               holdoffs_asked;
   int unsigned      cycle_count = 0;

   always #5 clock = ~clock;

   pixel_to_surface_format_packer_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ptsf_surface_checker surface_checker (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_ch),
      .rsp_mon           (rsp_ch),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatches        (mismatches),
      .words_outstanding (words_outstanding),
      .words_compared    (words_compared)
   );

   // Watchdog: a hung handshake or a result that never turns up ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d words outstanding",
                  cycle_count, words_outstanding);
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver. Its stall behaviour rotates through four styles of its own:
   // always ready, coin-toss stalls, rare stalls and a fixed one-in-three
   // pattern. When the stimulus asks for a hold-off, ready stays low for a
   // long count of cycles kept here, so that the pipeline fills and the
   // block has to push back on its input.
   initial begin
      int stall_left;
      int holdoffs_done;
      int rx_cycle;
      int style;
      rsp_ch.ready  = 1'b0;
      stall_left    = 0;
      holdoffs_done = 0;
      rx_cycle      = 0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (holdoffs_done != holdoffs_asked) begin
            holdoffs_done = holdoffs_asked;
            stall_left    = HOLDOFF_CYCLES;
         end
         style = (rx_cycle / 89) % 4;
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (style)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
               2:       rsp_ch.ready <= ($urandom_range(0, 9) != 0);
               default: rsp_ch.ready <= (rx_cycle % 3 != 0);
            endcase
         end
      end
   end

   function automatic cfg_type make_settings(input logic [1:0]          mode,
                                             input logic [1:0]          depth,
                                             input logic [SHIFTS_W-1:0] shifts,
                                             input logic [PIX_W-1:0]    red,
                                             input logic [PIX_W-1:0]    green,
                                             input logic [PIX_W-1:0]    blue,
                                             input logic [PIX_W-1:0]    alpha);
      cfg_type s;
      s.source_mode    = mode;
      s.output_depth   = depth;
      s.channel_shifts = shifts;
      s.red_mask       = red;
      s.green_mask     = green;
      s.blue_mask      = blue;
      s.alpha_mask     = alpha;
      return s;
   endfunction

   // A mask is all ones, all zeros or random, so that both extremes recur.
   function automatic logic [PIX_W-1:0] pick_mask();
      case ($urandom_range(0, 3))
         0:       return '1;
         1:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // Lowers valid and lets the pipeline run dry. The first edge lets the
   // checker count a word accepted at the edge we are standing on; the
   // cycles after the last result cover a palette write still in flight,
   // since that produces nothing to wait for.
   task automatic drain_pipeline();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (words_outstanding != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all seven registers back to back once the block is idle. The
   // enable stays high across the writes and is lowered once at the end.
   task automatic apply_settings(input cfg_type s);
      logic [CSR_DATA_W-1:0] values [7];
      drain_pipeline();
      values[REG_SOURCE_MODE]    = CSR_DATA_W'(s.source_mode);
      values[REG_OUTPUT_DEPTH]   = CSR_DATA_W'(s.output_depth);
      values[REG_CHANNEL_SHIFTS] = CSR_DATA_W'(s.channel_shifts);
      values[REG_RED_MASK]       = s.red_mask;
      values[REG_GREEN_MASK]     = s.green_mask;
      values[REG_BLUE_MASK]      = s.blue_mask;
      values[REG_ALPHA_MASK]     = s.alpha_mask;
      for (int i = REG_SOURCE_MODE; i <= REG_ALPHA_MASK; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_ADDR_W'(i);
         csr_wdata <= values[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      active_cfg = s;
      settings_applied++;
   endtask

   // Offers one word and returns once it has been accepted. Within a burst
   // valid simply stays high from one word to the next; between bursts it
   // drops for a random gap unless gap_max is zero.
   task automatic push_word(input logic             act,
                            input logic [PIX_W-1:0] pix,
                            input logic [IDX_W-1:0] idx,
                            input logic [PIX_W-1:0] color);
      if (burst_left == 0) begin
         if (gap_max > 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
         burst_left = $urandom_range(1, burst_max);
      end
      req_ch.valid         <= 1'b1;
      req_ch.action        <= act;
      req_ch.pixel_value   <= pix;
      req_ch.palette_index <= idx;
      req_ch.palette_color <= color;
      do
         @(posedge clock);
      while (req_ch.ready !== 1'b1);
      burst_left--;
   endtask

   task automatic load_palette(input logic [IDX_W-1:0] idx, input logic [PIX_W-1:0] color);
      if (!palette_loaded[idx]) begin
         palette_loaded[idx] = 1'b1;
         loaded_entries.push_back(idx);
      end
      palette_loads++;
      push_word(ACTION_PAL_WRITE, $urandom, idx, color);
   endtask

   // Converts a pixel. In the palette modes the low byte is replaced by an
   // entry already loaded; the upper bits stay random as they are ignored.
   task automatic convert_pixel(input logic [PIX_W-1:0] pix);
      logic [PIX_W-1:0] value;
      value = pix;
      if (active_cfg.source_mode == MODE_INDEXED || active_cfg.source_mode == MODE_BITMAP)
         value[IDX_W-1:0] = loaded_entries[$urandom_range(0, loaded_entries.size() - 1)];
      pixels_sent++;
      push_word(ACTION_CONVERT, value, IDX_W'($urandom), $urandom);
   endtask

   initial begin
      cfg_type s;

      // Every input is at a known level from time zero.
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = REG_SOURCE_MODE;
      csr_wdata            = '0;
      req_ch.valid         = 1'b0;
      req_ch.action        = ACTION_CONVERT;
      req_ch.pixel_value   = '0;
      req_ch.palette_index = '0;
      req_ch.palette_color = '0;
      burst_left           = 0;
      burst_max            = 1;
      gap_max              = 0;
      pixels_sent          = 0;
      palette_loads        = 0;
      settings_applied     = 0;
      holdoffs_asked       = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part, mostly back to back. The reset settings are written
      // explicitly and then exercised with the pixel extremes and alternating
      // bit patterns.
      burst_max = 8;
      gap_max   = 2;
      apply_settings(make_settings(MODE_RGBA, DEPTH_32, '0, 32'h0000_00FF,
                                   32'h0000_FF00, 32'h00FF_0000, 32'hFF00_0000));
      convert_pixel(32'h0000_0000);
      convert_pixel(32'hFFFF_FFFF);
      convert_pixel(32'h0102_0304);
      convert_pixel(32'h5555_5555);
      convert_pixel(32'hAAAA_AAAA);

      // Palette writes at both ends of the table and one in between; the
      // pixel field of these words is random and must be ignored.
      load_palette(8'h00, 32'hFFFF_FFFF);
      load_palette(8'hFF, 32'h8040_2010);
      load_palette(8'h01, 32'h0F0F_0F0F);

      // Indexed look-ups, some with the unused upper pixel bits set.
      apply_settings(make_settings(MODE_INDEXED, DEPTH_32, '0, 32'h0000_00FF,
                                   32'h0000_FF00, 32'h00FF_0000, 32'hFF00_0000));
      push_word(ACTION_CONVERT, 32'hFFFF_FF00, 8'hFF, 32'hFFFF_FFFF);
      push_word(ACTION_CONVERT, 32'h0000_00FF, 8'h00, 32'h0000_0000);
      push_word(ACTION_CONVERT, 32'hABCD_EF01, 8'h5A, 32'hA5A5_A5A5);
      pixels_sent += 3;

      // Bitmap look-ups at 24 bits.
      apply_settings(make_settings(MODE_BITMAP, DEPTH_24, '0, 32'h0000_00FF,
                                   32'h0000_FF00, 32'h00FF_0000, 32'hFF00_0000));
      push_word(ACTION_CONVERT, 32'h0000_00FF, 8'h00, 32'h0000_0000);
      push_word(ACTION_CONVERT, 32'h1234_5600, 8'hFF, 32'hFFFF_FFFF);
      pixels_sent += 2;

      // Gray with alpha at 8 and 16 bits; the upper half of the pixel must
      // not leak into the result.
      apply_settings(make_settings(MODE_GRAY, DEPTH_8, '0, 32'h0000_00FF,
                                   32'h0000_FF00, 32'h00FF_0000, 32'hFF00_0000));
      convert_pixel(32'hFFFF_00AB);
      apply_settings(make_settings(MODE_GRAY, DEPTH_16, 20'h0_2108, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      convert_pixel(32'h0000_FF7F);

      // The largest shifts push most channel bits past bit 31.
      apply_settings(make_settings(MODE_RGBA, DEPTH_32, 20'hF_FFFF, '1, '1, '1, '1));
      convert_pixel(32'hFFFF_FFFF);
      convert_pixel(32'h8080_8080);

      // All masks closed: every pixel packs to zero.
      apply_settings(make_settings(MODE_RGBA, DEPTH_32, '0, '0, '0, '0, '0));
      convert_pixel(32'hFFFF_FFFF);

      // Random part. Each phase picks fresh settings, a fresh burst and gap
      // shape (sometimes with no gaps at all) and a mix of palette loads and
      // converts. In the fourth phase the receiver holds off for a long time
      // while words keep being offered.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 3))
            0:       s.channel_shifts = '0;
            1:       s.channel_shifts = '1;
            default: s.channel_shifts = SHIFTS_W'($urandom);
         endcase
         s = make_settings(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                           s.channel_shifts, pick_mask(), pick_mask(), pick_mask(),
                           pick_mask());
         apply_settings(s);
         gap_max   = $urandom_range(0, 6);
         burst_max = $urandom_range(1, 40);
         if (phase == 3)
            holdoffs_asked <= holdoffs_asked + 1;
         repeat (PHASE_WORDS) begin
            if ($urandom_range(0, 4) == 0)
               load_palette(IDX_W'($urandom_range(0, PALETTE_ENTRIES - 1)), $urandom);
            else
               convert_pixel($urandom);
         end
      end

      // Let everything drain, then give the verdict.
      drain_pipeline();
      repeat (4) @(posedge clock);
      $display("Covered %0d pixel words and %0d palette loads over %0d register settings,",
               pixels_sent, palette_loads, settings_applied);
      $display("with %0d packed words compared and %0d mismatches.",
               words_compared, mismatches);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### files.f
src/ptsf_pkg.sv
src/ptsf_if.sv
src/ptsf_ram.sv
src/ptsf_csr.sv
src/ptsf_pack.sv
src/pixel_to_surface_format_packer_top.sv
verif/ptsf_surface_checker.sv
verif/pixel_to_surface_format_packer_top_tb.sv
